// ----- rtl/asid_tagged_lru_tlb_top_defines.svh -----
// assertion macros used by the checker file of the tlb
// no dependencies; clk and rst_n are taken from the including scope
`ifndef ASID_TAGGED_LRU_TLB_TOP_DEFINES_SVH
`define ASID_TAGGED_LRU_TLB_TOP_DEFINES_SVH

// checked only while out of reset
`define ATLB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ATLB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/atlb_pkg.sv -----
// shared types, codes and constants of the asid tagged lru tlb
// no dependencies; imported by every rtl module of the block except atlb_mem
package atlb_pkg;

  localparam int ENTRIES_MAX_DEF = 256;
  localparam int PROCS_DEF       = 8;
  localparam int PAGE_BITS_DEF   = 28;

  localparam int PAGE_NUM_W  = 28;
  localparam int ASID_W      = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 9;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 8;

  localparam int ENTRIES_MIN = 8;
  localparam int ENTRIES_RST = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TLB_MODE = 1'b0,
    REG_ENTRIES  = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_LOOKUP     = 1'b0,
    OP_INVALIDATE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    OUT_MISS_FILL = 2'd0,
    OUT_REVIVED   = 2'd1,
    OUT_HIT       = 2'd2,
    OUT_INV_DONE  = 2'd3
  } outcome_t;

  typedef struct packed {
    outcome_t outcome;
    logic     invalidated_any;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/atlb_mem.sv -----
// entry memory of the tlb: one write port, one read port, registered read data
// depends on nothing; sized by its parameters
module atlb_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 40
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/atlb_ctrl.sv -----
// request sequencer of the tlb: clearing pass, tag scan and lru update pass
// depends on atlb_pkg; drives the ports of atlb_mem
module atlb_ctrl #(
  parameter int ENTRIES_MAX = atlb_pkg::ENTRIES_MAX_DEF,
  parameter int PROCS       = atlb_pkg::PROCS_DEF,
  parameter int PAGE_BITS   = atlb_pkg::PAGE_BITS_DEF,
  parameter int CNT_W       = 9,
  parameter int ADDR_W      = 11,
  parameter int ENT_W       = 40
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            restart,
  input  logic                            mode,
  input  logic [CNT_W-1:0]                n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  atlb_pkg::opcode_t               in_op,
  input  logic [atlb_pkg::PAGE_NUM_W-1:0] in_page,
  input  logic [atlb_pkg::ASID_W-1:0]     in_asid,
  output logic                            res_valid,
  input  logic                            res_ready,
  output atlb_pkg::result_t               res,
  output logic                            mem_we,
  output logic [ADDR_W-1:0]               mem_waddr,
  output logic [ENT_W-1:0]                mem_wdata,
  output logic [ADDR_W-1:0]               mem_raddr,
  input  logic [ENT_W-1:0]                mem_rdata
);
  import atlb_pkg::*;

  localparam int IDX_W  = $clog2(ENTRIES_MAX);
  localparam int BANK_W = (PROCS > 1) ? $clog2(PROCS) : 1;

  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic [ASID_W-1:0]    asid;
    logic                 valid;
    logic [IDX_W-1:0]     rank;
  } entry_t;

  function automatic logic [BANK_W-1:0] bank_of(input logic [ASID_W-1:0] a);
    logic [ASID_W-1:0] v;
    v = a;
    for (int k = 0; k < (1 << ASID_W); k++) begin
      if (int'(v) >= PROCS) begin
        v = v - ASID_W'(PROCS);
      end
    end
    return BANK_W'(v);
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [BANK_W-1:0] b,
                                                input logic [IDX_W-1:0] i);
    return ADDR_W'(b) * ADDR_W'(ENTRIES_MAX) + ADDR_W'(i);
  endfunction

  state_t               st_r, st_nxt;
  logic [CNT_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 p_vld_r, p_vld_nxt;
  logic [IDX_W-1:0]     p_idx_r, p_idx_nxt;
  opcode_t              op_r, op_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic [ASID_W-1:0]    key_r, key_nxt;
  logic [BANK_W-1:0]    bank_r, bank_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     best_rank_r, best_rank_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic                 best_valid_r, best_valid_nxt;
  logic [IDX_W-1:0]     victim_r, victim_nxt;
  logic                 any_r, any_nxt;
  logic [IDX_W-1:0]     tgt_idx_r, tgt_idx_nxt;
  logic [IDX_W-1:0]     tgt_rank_r, tgt_rank_nxt;
  logic                 fill_r, fill_nxt;
  outcome_t             outcome_r, outcome_nxt;
  logic [BANK_W-1:0]    clr_bank_r, clr_bank_nxt;
  logic [IDX_W-1:0]     clr_idx_r, clr_idx_nxt;

  entry_t           rd_ent;
  entry_t           upd_ent;
  entry_t           clr_ent;
  logic             match;
  logic             issue;
  logic             pass_end;
  logic             clr_last;
  logic [CNT_W-1:0] n_m1;

  assign rd_ent   = entry_t'(mem_rdata);
  assign match    = (rd_ent.page == page_r) && (rd_ent.asid == key_r);
  assign n_m1     = n - CNT_W'(1);
  assign issue    = ((st_r == ST_SCAN) || (st_r == ST_UPDATE)) && (rd_idx_r != n);
  // last entry issued and its read data consumed
  assign pass_end = (rd_idx_r == n) && !p_vld_r;
  assign clr_last = (clr_idx_r == IDX_W'(ENTRIES_MAX - 1)) &&
                    (clr_bank_r == BANK_W'(PROCS - 1));

  always_comb begin
    upd_ent = rd_ent;
    if (p_idx_r == tgt_idx_r) begin
      upd_ent.rank  = '0;
      upd_ent.valid = 1'b1;
      if (fill_r) begin
        upd_ent.page = page_r;
        upd_ent.asid = key_r;
      end
    end else if (rd_ent.rank < tgt_rank_r) begin
      upd_ent.rank = rd_ent.rank + IDX_W'(1);
    end
  end

  always_comb begin
    clr_ent       = '0;
    clr_ent.rank  = clr_idx_r;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR: begin
        if (clr_last) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) st_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (pass_end) st_nxt = (op_r == OP_INVALIDATE) ? ST_DONE : ST_UPDATE;
      end
      ST_UPDATE: begin
        if (pass_end) st_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_CLEAR;
    endcase
    if (restart) st_nxt = ST_CLEAR;
  end

  // outputs and memory port control
  always_comb begin
    in_ready  = (st_r == ST_IDLE);
    res_valid = (st_r == ST_DONE);
    res       = '{outcome: outcome_r, invalidated_any: any_r};
    mem_raddr = addr_of(bank_r, rd_idx_r[IDX_W-1:0]);
    mem_we    = 1'b0;
    mem_waddr = addr_of(bank_r, p_idx_r);
    mem_wdata = upd_ent;
    case (st_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_of(clr_bank_r, clr_idx_r);
        mem_wdata = clr_ent;
      end
      ST_SCAN: begin
        mem_we          = p_vld_r && (op_r == OP_INVALIDATE) && match;
        mem_wdata       = rd_ent;
        mem_wdata[IDX_W] = 1'b0;
      end
      ST_UPDATE: begin
        mem_we = p_vld_r;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // datapath
  always_comb begin
    rd_idx_nxt     = rd_idx_r;
    p_vld_nxt      = 1'b0;
    p_idx_nxt      = rd_idx_r[IDX_W-1:0];
    op_nxt         = op_r;
    page_nxt       = page_r;
    key_nxt        = key_r;
    bank_nxt       = bank_r;
    found_nxt      = found_r;
    best_rank_nxt  = best_rank_r;
    best_idx_nxt   = best_idx_r;
    best_valid_nxt = best_valid_r;
    victim_nxt     = victim_r;
    any_nxt        = any_r;
    tgt_idx_nxt    = tgt_idx_r;
    tgt_rank_nxt   = tgt_rank_r;
    fill_nxt       = fill_r;
    outcome_nxt    = outcome_r;
    clr_bank_nxt   = clr_bank_r;
    clr_idx_nxt    = clr_idx_r;
    case (st_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + IDX_W'(1);
        if (clr_idx_r == IDX_W'(ENTRIES_MAX - 1)) begin
          clr_idx_nxt  = '0;
          clr_bank_nxt = clr_bank_r + BANK_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_op;
          page_nxt   = in_page[PAGE_BITS-1:0];
          bank_nxt   = mode ? bank_of(in_asid) : '0;
          key_nxt    = mode ? '0 : in_asid;
          rd_idx_nxt = '0;
          found_nxt  = 1'b0;
          any_nxt    = 1'b0;
          victim_nxt = '0;
        end
      end
      ST_SCAN: begin
        p_vld_nxt = issue;
        if (issue) rd_idx_nxt = rd_idx_r + CNT_W'(1);
        if (p_vld_r) begin
          if (op_r == OP_INVALIDATE) begin
            if (match && rd_ent.valid) any_nxt = 1'b1;
          end else begin
            // several matches only after a clearing pass: most recent one wins
            if (match && (!found_r || (rd_ent.rank < best_rank_r))) begin
              found_nxt      = 1'b1;
              best_rank_nxt  = rd_ent.rank;
              best_idx_nxt   = p_idx_r;
              best_valid_nxt = rd_ent.valid;
            end
            if (CNT_W'(rd_ent.rank) == n_m1) victim_nxt = p_idx_r;
          end
        end
        if (pass_end) begin
          rd_idx_nxt   = '0;
          tgt_idx_nxt  = found_r ? best_idx_r : victim_r;
          tgt_rank_nxt = found_r ? best_rank_r : n_m1[IDX_W-1:0];
          fill_nxt     = !found_r;
          if (op_r == OP_INVALIDATE) begin
            outcome_nxt = OUT_INV_DONE;
          end else if (found_r) begin
            outcome_nxt = best_valid_r ? OUT_HIT : OUT_REVIVED;
          end else begin
            outcome_nxt = OUT_MISS_FILL;
          end
        end
      end
      ST_UPDATE: begin
        p_vld_nxt = issue;
        if (issue) rd_idx_nxt = rd_idx_r + CNT_W'(1);
      end
      default: p_vld_nxt = 1'b0;
    endcase
    if (restart) begin
      clr_bank_nxt = '0;
      clr_idx_nxt  = '0;
      p_vld_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_CLEAR;
      p_vld_r    <= 1'b0;
      clr_bank_r <= '0;
      clr_idx_r  <= '0;
    end else begin
      st_r       <= st_nxt;
      p_vld_r    <= p_vld_nxt;
      clr_bank_r <= clr_bank_nxt;
      clr_idx_r  <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    p_idx_r      <= p_idx_nxt;
    op_r         <= op_nxt;
    page_r       <= page_nxt;
    key_r        <= key_nxt;
    bank_r       <= bank_nxt;
    found_r      <= found_nxt;
    best_rank_r  <= best_rank_nxt;
    best_idx_r   <= best_idx_nxt;
    best_valid_r <= best_valid_nxt;
    victim_r     <= victim_nxt;
    any_r        <= any_nxt;
    tgt_idx_r    <= tgt_idx_nxt;
    tgt_rank_r   <= tgt_rank_nxt;
    fill_r       <= fill_nxt;
    outcome_r    <= outcome_nxt;
  end

endmodule

// ----- rtl/asid_tagged_lru_tlb_top.sv -----
// a lookup takes a scan pass over the n tags (n being entries_in_use) and then a second pass that
// rewrites the lru ranks; an invalidate takes only the scan pass. one request at a time: the next
// is taken once the result has moved on to the output register. the pace is set by the single read
// port of the entry memory.
// reset (rst_n, synchronous) and every config write start a clearing pass over all
// PROCS*ENTRIES_MAX entries (2048 by default) during which in_tready stays low.
module asid_tagged_lru_tlb_top #(
  parameter int ENTRIES_MAX = atlb_pkg::ENTRIES_MAX_DEF,
  parameter int PROCS       = atlb_pkg::PROCS_DEF,
  parameter int PAGE_BITS   = atlb_pkg::PAGE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [atlb_pkg::IN_TDATA_W-1:0]  in_tdata,   // page_number, asid
  input  logic [0:0]                       in_tuser,   // opcode
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [atlb_pkg::OUT_TDATA_W-1:0] out_tdata,  // outcome, invalidated_any
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [atlb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [atlb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import atlb_pkg::*;

  localparam int CNT_W  = $clog2(ENTRIES_MAX + 1);
  localparam int IDX_W  = $clog2(ENTRIES_MAX);
  localparam int DEPTH  = PROCS * ENTRIES_MAX;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ENT_W  = PAGE_BITS + ASID_W + 1 + IDX_W;
  localparam int N_RST  = (ENTRIES_RST > ENTRIES_MAX) ? ENTRIES_MAX : ENTRIES_RST;

  logic             mode_r, mode_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_res_r;
  logic [CFG_DATA_W-1:0] n_clamp;
  logic             cfg_wr;

  logic             res_valid;
  logic             res_ready;
  result_t          res;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ENT_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [ENT_W-1:0] mem_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    if (cfg_data < CFG_DATA_W'(ENTRIES_MIN)) begin
      n_clamp = CFG_DATA_W'(ENTRIES_MIN);
    end else if (cfg_data > CFG_DATA_W'(ENTRIES_MAX)) begin
      n_clamp = CFG_DATA_W'(ENTRIES_MAX);
    end else begin
      n_clamp = cfg_data;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    n_nxt    = n_r;
    if (cfg_wr) begin
      case (cfg_reg_t'(cfg_index))
        REG_TLB_MODE: mode_nxt = cfg_data[0];
        REG_ENTRIES:  n_nxt    = CNT_W'(n_clamp);
        default:      mode_nxt = mode_r;
      endcase
    end
  end

  // output register: the next request may start while a result waits here
  assign res_ready     = !out_valid_r || out_tready;
  assign out_valid_nxt = (res_valid && res_ready) || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      n_r         <= CNT_W'(N_RST);
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 3){1'b0}}, out_res_r.invalidated_any,
                       out_res_r.outcome};

  atlb_ctrl #(
    .ENTRIES_MAX (ENTRIES_MAX),
    .PROCS       (PROCS),
    .PAGE_BITS   (PAGE_BITS),
    .CNT_W       (CNT_W),
    .ADDR_W      (ADDR_W),
    .ENT_W       (ENT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (cfg_wr),
    .mode      (mode_r),
    .n         (n_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (opcode_t'(in_tuser[0])),
    .in_page   (in_tdata[PAGE_NUM_W-1:0]),
    .in_asid   (in_tdata[PAGE_NUM_W +: ASID_W]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  atlb_mem #(
    .DEPTH (DEPTH),
    .AW    (ADDR_W),
    .DW    (ENT_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ----- rtl/atlb_checker.sv -----
// port level checks of the tlb top, attached by the bind at the end
// depends on atlb_pkg and asid_tagged_lru_tlb_top_defines.svh
`include "asid_tagged_lru_tlb_top_defines.svh"

module atlb_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [atlb_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             cfg_valid,
  input logic                             cfg_ready
);
  import atlb_pkg::*;

  // reset leaves no result pending and starts the clearing pass
  `ATLB_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_tvalid && !in_tready, "busy after reset")

  // one request at a time: a new request is refused right after one is taken
  `ATLB_ASSERT(a_one_at_a_time, in_tvalid && in_tready |=> !in_tready, "second request taken")

  // a config write starts the clearing pass
  `ATLB_ASSERT(a_cfg_clears, cfg_valid && cfg_ready |=> !in_tready, "ready during clear")

  // only an invalidate can report cleared entries
  `ATLB_ASSERT(a_any_only_inv, out_tvalid && out_tdata[2] |-> out_tdata[1:0] == 2'b11, "bad flag")

  `ATLB_ASSERT(a_out_hold, out_tvalid && !out_tready |=> $stable(out_tdata), "result changed")

endmodule

bind asid_tagged_lru_tlb_top atlb_checker u_atlb_checker (.*);

// ----- sim/tb_top.sv -----
// testbench for asid_tagged_lru_tlb_top: a directed table, then random lookups and invalidates
// over several table settings, checked against an lru model kept inside the bench
// depends on atlb_pkg and the rtl top module
module tb_top;
  import atlb_pkg::*;

  localparam int SLOTS         = ENTRIES_MAX_DEF;
  localparam int BANKS         = PROCS_DEF;
  localparam int MAX_WAIT      = 18;
  localparam int SETTLE_CYCLES = 2 * SLOTS + 16;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int N_PHASES      = 7;
  localparam int POOL_SIZE     = 16;

  typedef struct {
    bit                    is_cfg;
    cfg_reg_t              reg_idx;
    bit [CFG_DATA_W-1:0]   reg_val;
    opcode_t               op;
    bit [PAGE_NUM_W-1:0]   page;
    bit [ASID_W-1:0]       asid;
    bit                    typed;
    result_t               res;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // page_number, asid
  logic [0:0]             in_tuser;   // opcode
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // outcome, invalidated_any
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  asid_tagged_lru_tlb_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // lru model of all banks
  bit [PAGE_NUM_W-1:0] tlb_page  [SLOTS*BANKS];
  bit [ASID_W-1:0]     tlb_asid  [SLOTS*BANKS];
  bit                  tlb_valid [SLOTS*BANKS];
  int                  tlb_rank  [SLOTS*BANKS];
  bit                  mode_per_proc;
  int                  entries_cfg;

  result_t   expected_q[$];
  stim_row_t directed_rows[$];
  int        errors;
  int        requests_sent;
  int        results_seen;
  int        outcome_seen[4];
  int        cycles;
  bit        send_calm;

  int phase_mode  [N_PHASES] = '{0, 1, 0, 1, 0, 1, 0};
  int phase_size  [N_PHASES] = '{8, 16, 12, 5, 32, 300, 256};
  int phase_count [N_PHASES] = '{190, 190, 150, 150, 130, 60, 60};

  bit [PAGE_NUM_W-1:0] page_pool [POOL_SIZE];
  bit [PAGE_NUM_W-1:0] rnd_page;
  bit [ASID_W-1:0]     rnd_asid;
  opcode_t             rnd_op;
  int                  span;

  function automatic void clear_tlb();
    for (int b = 0; b < BANKS; b++) begin
      for (int i = 0; i < SLOTS; i++) begin
        tlb_page[b*SLOTS+i]  = '0;
        tlb_asid[b*SLOTS+i]  = '0;
        tlb_valid[b*SLOTS+i] = 1'b0;
        tlb_rank[b*SLOTS+i]  = i;
      end
    end
  endfunction

  function automatic void make_recent(int base, int n, int idx);
    int r;
    r = tlb_rank[base+idx];
    for (int k = 0; k < n; k++) begin
      if (tlb_rank[base+k] < r) tlb_rank[base+k]++;
    end
    tlb_rank[base+idx] = 0;
  endfunction

  function automatic void tlb_write_reg(cfg_reg_t idx, bit [CFG_DATA_W-1:0] val);
    case (idx)
      REG_TLB_MODE: mode_per_proc = val[0];
      REG_ENTRIES: begin
        entries_cfg = val;
        if (entries_cfg < ENTRIES_MIN) entries_cfg = ENTRIES_MIN;
        if (entries_cfg > SLOTS) entries_cfg = SLOTS;
      end
      default: ;
    endcase
    clear_tlb();
  endfunction

  function automatic result_t tlb_access(opcode_t op, bit [PAGE_NUM_W-1:0] page,
                                         bit [ASID_W-1:0] asid);
    result_t         r;
    int              base;
    int              n;
    int              best;
    int              best_rank;
    int              victim;
    bit [ASID_W-1:0] key;
    bit              found;
    n = entries_cfg;
    base = mode_per_proc ? (asid % BANKS) * SLOTS : 0;
    key = mode_per_proc ? '0 : asid;
    r.outcome = OUT_MISS_FILL;
    r.invalidated_any = 1'b0;
    if (op == OP_INVALIDATE) begin
      r.outcome = OUT_INV_DONE;
      for (int k = 0; k < n; k++) begin
        if (tlb_page[base+k] == page && tlb_asid[base+k] == key) begin
          if (tlb_valid[base+k]) r.invalidated_any = 1'b1;
          tlb_valid[base+k] = 1'b0;
        end
      end
    end else begin
      found = 1'b0;
      best = 0;
      best_rank = 1 << 30;
      // the valid bit is ignored here; the most recent matching entry wins
      for (int k = 0; k < n; k++) begin
        if (tlb_page[base+k] == page && tlb_asid[base+k] == key &&
            tlb_rank[base+k] < best_rank) begin
          best_rank = tlb_rank[base+k];
          best = k;
          found = 1'b1;
        end
      end
      if (found) begin
        if (tlb_valid[base+best]) r.outcome = OUT_HIT;
        else r.outcome = OUT_REVIVED;
        tlb_valid[base+best] = 1'b1;
        make_recent(base, n, best);
      end else begin
        victim = 0;
        for (int k = 0; k < n; k++) begin
          if (tlb_rank[base+k] == n - 1) begin
            victim = k;
            break;
          end
        end
        tlb_page[base+victim]  = page;
        tlb_asid[base+victim]  = key;
        tlb_valid[base+victim] = 1'b1;
        make_recent(base, n, victim);
      end
    end
    return r;
  endfunction

  function automatic stim_row_t req_row(opcode_t op, bit [PAGE_NUM_W-1:0] page,
                                        bit [ASID_W-1:0] asid, bit typed,
                                        outcome_t oc, bit any);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.reg_idx = REG_TLB_MODE;
    row.reg_val = '0;
    row.op = op;
    row.page = page;
    row.asid = asid;
    row.typed = typed;
    row.res.outcome = oc;
    row.res.invalidated_any = any;
    return row;
  endfunction

  function automatic stim_row_t reg_row(cfg_reg_t idx, bit [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row = req_row(OP_LOOKUP, '0, '0, 1'b0, OUT_MISS_FILL, 1'b0);
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  // all tasks start and end at a falling edge
  task automatic send_request(input opcode_t op, input bit [PAGE_NUM_W-1:0] page,
                              input bit [ASID_W-1:0] asid, input bit typed,
                              input result_t typed_res);
    int      gap;
    result_t r;
    gap = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_TDATA_W'({asid, page});
    do @(posedge clk); while (!in_tready);
    r = tlb_access(op, page, asid);
    expected_q.push_back(typed ? typed_res : r);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (expected_q.size() != 0);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input bit [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tlb_write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycles, expected_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stalls, sometimes held until the result is already waiting
  initial begin : result_sink
    int      stall;
    int      calm_left;
    bit      calm;
    bit      hold_for_valid;
    result_t got;
    result_t want;
    calm_left = 0;
    calm = 1'b0;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (calm_left == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        calm_left = 30;
      end
      calm_left--;
      stall = calm ? 0 : $urandom_range(0, MAX_WAIT);
      hold_for_valid = !calm && ($urandom_range(0, 1) == 1);
      if (stall > 0 || hold_for_valid) begin
        out_tready <= 1'b0;
        if (hold_for_valid) begin
          do @(posedge clk); while (!out_tvalid);
          @(negedge clk);
        end
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got.outcome = outcome_t'(out_tdata[1:0]);
      got.invalidated_any = out_tdata[2];
      results_seen++;
      outcome_seen[out_tdata[1:0]]++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: outcome %0d invalidated_any %0d",
                 $time, got.outcome, got.invalidated_any);
      end else begin
        want = expected_q.pop_front();
        if (got.outcome !== want.outcome) begin
          errors++;
          $display("%0t: outcome mismatch: expected %0d actual %0d",
                   $time, want.outcome, got.outcome);
        end
        if (got.invalidated_any !== want.invalidated_any) begin
          errors++;
          $display("%0t: invalidated_any mismatch: expected %0d actual %0d",
                   $time, want.invalidated_any, got.invalidated_any);
        end
      end
      @(negedge clk);
    end
  end

  initial begin : request_source
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_TLB_MODE;
    cfg_data = '0;
    cycles = 0;
    errors = 0;
    requests_sent = 0;
    results_seen = 0;
    send_calm = 1'b0;
    for (int k = 0; k < 4; k++) outcome_seen[k] = 0;
    mode_per_proc = 1'b0;
    entries_cfg = ENTRIES_RST;
    clear_tlb();

    // shared table, 64 entries after reset; reset tags are page 0 asid 0, invalid
    directed_rows.push_back(req_row(OP_LOOKUP, 28'h0, 3'd0, 1, OUT_REVIVED, 0));
    directed_rows.push_back(req_row(OP_LOOKUP, 28'h0, 3'd0, 1, OUT_HIT, 0));
    directed_rows.push_back(req_row(OP_INVALIDATE, 28'h0, 3'd0, 1, OUT_INV_DONE, 1));
    directed_rows.push_back(req_row(OP_INVALIDATE, 28'h0, 3'd0, 1, OUT_INV_DONE, 0));
    directed_rows.push_back(req_row(OP_LOOKUP, 28'hFFFFFFF, 3'd7, 1, OUT_MISS_FILL, 0));
    directed_rows.push_back(req_row(OP_LOOKUP, 28'hFFFFFFF, 3'd7, 1, OUT_HIT, 0));
    directed_rows.push_back(req_row(OP_LOOKUP, 28'hFFFFFFF, 3'd0, 1, OUT_MISS_FILL, 0));
    directed_rows.push_back(req_row(OP_INVALIDATE, 28'h5555555, 3'd5, 1, OUT_INV_DONE, 0));
    directed_rows.push_back(req_row(OP_LOOKUP, 28'h0, 3'd0, 0, OUT_MISS_FILL, 0));
    // one bank per process
    directed_rows.push_back(reg_row(REG_TLB_MODE, 9'd1));
    directed_rows.push_back(req_row(OP_LOOKUP, 28'h0, 3'd5, 1, OUT_REVIVED, 0));
    directed_rows.push_back(req_row(OP_LOOKUP, 28'hAAAAAAA, 3'd7, 1, OUT_MISS_FILL, 0));
    directed_rows.push_back(req_row(OP_LOOKUP, 28'hAAAAAAA, 3'd7, 1, OUT_HIT, 0));
    directed_rows.push_back(req_row(OP_LOOKUP, 28'hAAAAAAA, 3'd6, 1, OUT_MISS_FILL, 0));
    directed_rows.push_back(req_row(OP_INVALIDATE, 28'hAAAAAAA, 3'd7, 1, OUT_INV_DONE, 1));
    directed_rows.push_back(req_row(OP_LOOKUP, 28'hAAAAAAA, 3'd7, 1, OUT_REVIVED, 0));
    // entry count below the minimum clamps to 8, above the maximum to 256
    directed_rows.push_back(reg_row(REG_ENTRIES, 9'd0));
    directed_rows.push_back(req_row(OP_LOOKUP, 28'h0, 3'd7, 1, OUT_REVIVED, 0));
    directed_rows.push_back(reg_row(REG_ENTRIES, 9'd511));
    directed_rows.push_back(req_row(OP_LOOKUP, 28'h1234567, 3'd3, 1, OUT_MISS_FILL, 0));
    directed_rows.push_back(req_row(OP_INVALIDATE, 28'h0, 3'd3, 1, OUT_INV_DONE, 0));
    // count that is not a power of two, back to the shared table
    directed_rows.push_back(reg_row(REG_ENTRIES, 9'd12));
    directed_rows.push_back(reg_row(REG_TLB_MODE, 9'd0));
    directed_rows.push_back(req_row(OP_LOOKUP, 28'h0, 3'd1, 1, OUT_MISS_FILL, 0));
    directed_rows.push_back(req_row(OP_LOOKUP, 28'h0, 3'd1, 1, OUT_HIT, 0));

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg)
        write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_val);
      else
        send_request(directed_rows[r].op, directed_rows[r].page, directed_rows[r].asid,
                     directed_rows[r].typed, directed_rows[r].res);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(REG_TLB_MODE, CFG_DATA_W'(phase_mode[p]));
      write_reg(REG_ENTRIES, CFG_DATA_W'(phase_size[p]));
      for (int k = 0; k < POOL_SIZE; k++) page_pool[k] = PAGE_NUM_W'($urandom);
      page_pool[0] = '0;
      // a narrow page pool on small tables keeps hits and evictions both common
      span = (entries_cfg < 16) ? 8 : POOL_SIZE;
      for (int i = 0; i < phase_count[p]; i++) begin
        if (i % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
        if (i == phase_count[p] / 2 || $urandom_range(0, 59) == 0) wait_drained();
        rnd_op = ($urandom_range(0, 3) == 0) ? OP_INVALIDATE : OP_LOOKUP;
        if ($urandom_range(0, 9) < 8) rnd_page = page_pool[$urandom_range(0, span - 1)];
        else rnd_page = PAGE_NUM_W'($urandom);
        if (!mode_per_proc && $urandom_range(0, 4) != 0)
          rnd_asid = ASID_W'($urandom_range(0, 1));
        else
          rnd_asid = ASID_W'($urandom_range(0, 7));
        send_request(rnd_op, rnd_page, rnd_asid, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d requests over both table modes and sizes 8 to 256, %0d results",
             requests_sent, results_seen);
    $display("fills %0d, revivals %0d, hits %0d, invalidates %0d, mismatches %0d",
             outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3], errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
